// ===== hw/rtl/group_reverse_reorder_defines.svh =====
// Assertion macros for the group reverse reorder block.
// Used by the top level only; no other dependencies.
`ifndef GROUP_REVERSE_REORDER_DEFINES_SVH
`define GROUP_REVERSE_REORDER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define GRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grr assertion failed");
// Next-cycle implication, checked out of reset.
`define GRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grr assertion failed");
`else
`define GRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/grr_pkg.sv =====
// Shared types and constants for the group reverse reorder block.
// No dependencies.
`timescale 1ns / 1ps

package grr_pkg;

  localparam int unsigned MAX_GROUP_DEF = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned GS_W          = 7;
  localparam logic [GS_W-1:0] GS_RESET  = 7'd3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_OUT
  } grr_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic store;      // write accepted beat into the store
    logic rd_en;      // read one held element into the output register
    logic step_down;  // move read pointer to the next lower entry
    logic finish;     // run delivered, empty the store
  } grr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit_now;   // current input beat closes a group
    logic run_done;   // output register holds the last element of the run
  } grr_sts_t;

endpackage

// ===== hw/rtl/grr_ctrl.sv =====
// Controller state machine: load, read and output phases.
// Depends on grr_pkg.
`timescale 1ns / 1ps

module grr_ctrl
  import grr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  grr_sts_t sts,
  output grr_cmd_t cmd
);

  grr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.store = 1'b1;
          if (sts.emit_now) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.run_done) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_LOAD;
          end else begin
            cmd.step_down = 1'b1;
            state_nxt     = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/grr_dp.sv =====
// Datapath: group store memory, fill count, read pointer, output register
// and the group size register. Depends on grr_pkg.
`timescale 1ns / 1ps

module grr_dp
  import grr_pkg::*;
#(
  parameter int unsigned MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [GS_W-1:0]   cfg_wr_data,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_last,
  input  grr_cmd_t          cmd,
  output grr_sts_t          sts,
  output logic [DATA_W-1:0] out_value,
  output logic              out_group_end,
  output logic              out_seq_end
);

  localparam int unsigned ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int unsigned CMP_W  = (CNT_W > GS_W) ? CNT_W : GS_W;

  logic [DATA_W-1:0] mem [MAX_GROUP];

  logic [GS_W-1:0]   group_size_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic              last_r, last_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              gend_r;
  logic              send_r;

  logic [CNT_W-1:0]  fill_inc;
  logic [CMP_W-1:0]  fill_cmp;

  assign fill_inc = fill_r + CNT_W'(1);
  assign fill_cmp = CMP_W'(fill_inc);

  // Close the group on the last beat, at the configured size, or at capacity.
  assign sts.emit_now = in_last
                     || (fill_cmp >= CMP_W'(group_size_r))
                     || (fill_cmp >= CMP_W'(MAX_GROUP));
  assign sts.run_done = gend_r;

  always_comb begin
    fill_nxt   = fill_r;
    rd_ptr_nxt = rd_ptr_r;
    last_nxt   = last_r;
    if (cmd.store) begin
      if (sts.emit_now) begin
        rd_ptr_nxt = fill_r[ADDR_W-1:0];
        last_nxt   = in_last;
      end else begin
        fill_nxt = fill_inc;
      end
    end
    if (cmd.step_down) begin
      rd_ptr_nxt = rd_ptr_r - ADDR_W'(1);
    end
    if (cmd.finish) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GS_RESET;
      fill_r       <= '0;
      rd_ptr_r     <= '0;
      last_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        group_size_r <= cfg_wr_data;
      end
      fill_r   <= fill_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill_r[ADDR_W-1:0]] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
      gend_r    <= (rd_ptr_r == '0);
      send_r    <= (rd_ptr_r == '0) && last_r;
    end
  end

  assign out_value     = rd_data_r;
  assign out_group_end = gend_r;
  assign out_seq_end   = send_r;

endmodule

// ===== hw/rtl/group_reverse_reorder.sv =====
// Top level of the group reverse reorder block: controller plus datapath.
// Depends on grr_pkg, grr_ctrl, grr_dp and group_reverse_reorder_defines.svh.
//
//   channel | dir | tdata            | tlast     | tuser
//   --------+-----+------------------+-----------+--------
//   in_     | in  | elem_value[31:0] | seq_last  | -
//   out_    | out | out_value[31:0]  | group_end | seq_end
//   cfg_    | in  | group_size[6:0]  | -         | -
//
// Input beats are taken one per cycle while a group fills. Once a group
// closes (size reached, store full, or the last beat of the sequence) the
// held elements go out newest first, each by a registered read of the
// single-port store followed by its output beat. Reset empties the store
// at once; stalls on out_tready hold the beat.
`timescale 1ns / 1ps
`include "group_reverse_reorder_defines.svh"

module group_reverse_reorder
  import grr_pkg::*;
#(
  parameter int unsigned MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [GS_W-1:0]   cfg_wr_data,   // group_size[6:0]
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,      // elem_value[31:0]
  input  logic              in_tlast,      // seq_last
  // output stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,     // out_value[31:0]
  output logic              out_tlast,     // group_end
  output logic              out_tuser      // seq_end
);

  grr_cmd_t cmd;
  grr_sts_t sts;

  // Sequence the load, read and output phases.
  grr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold the group, count it and walk it back out.
  grr_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_value      (in_tdata),
    .in_last       (in_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .out_value     (out_tdata),
    .out_group_end (out_tlast),
    .out_seq_end   (out_tuser)
  );

  // Loading and emitting never overlap.
  `GRR_ASSERT_IMP(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  // The sequence end only ever lands on the end of a run.
  `GRR_ASSERT_IMP(a_seq_end_on_run_end, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  // The last input beat of a sequence always starts an emission.
  `GRR_ASSERT_NXT(a_last_starts_emit, clk, rst_n, in_tvalid && in_tready && in_tlast,
                  !in_tready)
  // After the final beat of a run the block is back to loading.
  `GRR_ASSERT_NXT(a_run_end_reloads, clk, rst_n, out_tvalid && out_tready && out_tlast,
                  in_tready)

endmodule
